/* hdl/double_to_decimal_string_macros.svh */
// Assertion macros for the double-to-decimal formatter.
// Used by the top level only; no other dependencies.
`ifndef DOUBLE_TO_DECIMAL_STRING_MACROS_SVH
`define DOUBLE_TO_DECIMAL_STRING_MACROS_SVH

// Implication in the same cycle.
`define DTDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define DTDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/dtds_pkg.sv */
// Shared constants and types for the double-to-decimal formatter.
// No dependencies.
package dtds_pkg;
	localparam int MAX_FRACTION_DIGITS = 18;
	localparam logic [4:0] DEFAULT_DIGITS = 5'd6;
	// fraction held with this many binary places before scaling
	localparam int FRAC_W = 114;
	localparam int ACC_W  = 174;
	localparam int PW_W   = 60;
	// double-dabble unit size
	localparam int BCD_DIGITS = 19;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int INT_DIGITS = 10;

	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_DOT   = 7'h2E;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_NONE  = 7'h00;

	typedef struct packed {
		logic       start;
		logic [6:0] nbits;
	} bcd_ctl_t;
endpackage

/* hdl/dtds_in_if.sv */
// Input channel: one double per word.
// No dependencies.
interface dtds_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

/* hdl/dtds_out_if.sv */
// Output channel: one ASCII character per word.
// No dependencies.
interface dtds_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] text_char;
	logic       is_last;
	logic       out_of_range;

	modport source (output valid, output text_char, output is_last, output out_of_range,
		input ready);
	modport sink (input valid, input text_char, input is_last, input out_of_range,
		output ready);
endinterface

/* hdl/dtds_bcd.sv */
// Shared binary-to-BCD unit, shift-and-add-three, one bit per cycle.
// Depends on dtds_pkg.
module dtds_bcd import dtds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bcd_ctl_t          ctl,
	input  logic [63:0]       data,
	output logic              busy,
	output logic [BCD_W-1:0]  digits
);
	logic [6:0]       count_q;
	logic [63:0]      shreg_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	// add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.start) begin
			count_q <= ctl.nbits;
		end else if (count_q != 7'd0) begin
			count_q <= count_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			shreg_q <= data;
			bcd_q   <= '0;
		end else if (count_q != 7'd0) begin
			bcd_q   <= {adj[BCD_W-2:0], shreg_q[63]};
			shreg_q <= {shreg_q[62:0], 1'b0};
		end
	end

	assign busy   = (count_q != 7'd0);
	assign digits = bcd_q;
endmodule

/* hdl/double_to_decimal_string.sv */
// Top level: decodes a double, scales and rounds the fraction, converts to
// decimal and streams the text. Depends on dtds_pkg, dtds_in_if, dtds_out_if,
// dtds_bcd and double_to_decimal_string_macros.svh.
//
//  channel   dir   word                                     handshake
//  din       in    value_bits[63:0]                         valid/ready
//  dout      out   text_char[6:0], is_last, out_of_range    valid/ready
//  cfg       in    cfg_wr_data[4:0] (digits_after_point)    cfg_wr_en
//
// Per number: a decode step, p multiply-by-ten steps, the rounding and narrowing
// states S_RND, S_FIX and S_NAR, integer then fraction conversion in the shared
// BCD unit, then one character per cycle (up to 30) while the output is not
// stalled; the sign slot without a minus and up to 9 leading zeros are skipped.
// An error yields one out_of_range word. din.ready is high only between numbers.
// Output stalls hold the character register and pause the stream.
// Asynchronous reset clears control state; digits_after_point resets to 6.
`include "double_to_decimal_string_macros.svh"

module double_to_decimal_string import dtds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	dtds_in_if.sink     din,
	dtds_out_if.source  dout
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_ERR  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_RND  = 4'd4;
	localparam logic [3:0] S_FIX  = 4'd5;
	localparam logic [3:0] S_NAR  = 4'd6;
	localparam logic [3:0] S_BINT = 4'd7;
	localparam logic [3:0] S_BFRC = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;

	localparam logic [1:0] P_SIGN  = 2'd0;
	localparam logic [1:0] P_INT   = 2'd1;
	localparam logic [1:0] P_POINT = 2'd2;
	localparam logic [1:0] P_FRAC  = 2'd3;

	logic [3:0]        state_q;
	logic [4:0]        cfg_q, p_q, cnt_q, idx_q;
	logic [63:0]       bits_q, ip_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PW_W-1:0]   pw_q, rnd_q;
	logic              neg_q, nz_q, minus_q, started_q;
	logic [1:0]        phase_q;
	logic [3:0]        int_q [INT_DIGITS];
	logic [3:0]        frc_q [MAX_FRACTION_DIGITS];
	logic              ov_q, last_q, err_q;
	logic [6:0]        ch_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= DEFAULT_DIGITS;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	logic [4:0] p_clamp;
	assign p_clamp = (cfg_q > 5'(MAX_FRACTION_DIGITS)) ? 5'(MAX_FRACTION_DIGITS) : cfg_q;

	// decode of the captured double
	logic [10:0]       ex, shift;
	logic [52:0]       mant, fpart;
	logic [63:0]       ipart, fmask;
	logic [FRAC_W-1:0] fscaled;
	logic              err_d;
	always_comb begin
		ex    = bits_q[62:52];
		mant  = {ex != 11'd0, bits_q[51:0]};
		err_d = (ex == 11'h7FF) || (ex >= 11'd1086);
		if (ex == 11'd0)
			shift = 11'd1074;
		else if (ex < 11'd1075)
			shift = 11'd1075 - ex;
		else
			shift = 11'd0;
		fmask = (64'd1 << shift[5:0]) - 64'd1;
		if (ex >= 11'd1075) begin
			ipart = {11'd0, mant} << 4'(ex - 11'd1075);
			fpart = '0;
		end else if (shift >= 11'd64) begin
			ipart = '0;
			fpart = mant;
		end else begin
			ipart = {11'd0, mant} >> shift[5:0];
			fpart = mant & fmask[52:0];
		end
		if (shift != 11'd0 && shift < 11'(FRAC_W))
			fscaled = FRAC_W'(fpart) << 7'(11'(FRAC_W) - shift);
		else
			fscaled = '0;
	end

	// rounding sum and narrowing
	logic [ACC_W-1:0] rsum;
	logic [31:0]      narrowed, mag32;
	logic             minus_d;
	assign rsum     = acc_q + (ACC_W'(1) << (FRAC_W - 1));
	assign narrowed = neg_q ? 32'd0 - ip_q[31:0] : ip_q[31:0];
	assign minus_d  = narrowed[31] || (narrowed == 32'd0 && ip_q == 64'd0 && neg_q && nz_q);
	assign mag32    = narrowed[31] ? 32'd0 - narrowed : narrowed;

	// shared BCD unit
	bcd_ctl_t          bcd_ctl;
	logic [63:0]       bcd_data;
	logic              bcd_busy;
	logic [BCD_W-1:0]  bcd_digits;
	always_comb begin
		bcd_ctl.start = (state_q == S_NAR) || (state_q == S_BINT && !bcd_busy);
		bcd_ctl.nbits = (state_q == S_NAR) ? 7'd32 : 7'd64;
		bcd_data      = (state_q == S_NAR) ? {mag32, 32'd0} : {4'd0, rnd_q};
	end

	dtds_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bcd_ctl),
		.data   (bcd_data),
		.busy   (bcd_busy),
		.digits (bcd_digits)
	);

	// next character of the stream
	logic       slot_free, emit_v, emit_last;
	logic [6:0] emit_ch;
	logic [3:0] d_int, d_frc;
	assign slot_free = !ov_q || dout.ready;
	assign d_int     = int_q[idx_q[3:0]];
	assign d_frc     = frc_q[idx_q];
	always_comb begin
		emit_v    = 1'b0;
		emit_ch   = CH_NONE;
		emit_last = 1'b0;
		case (phase_q)
			P_SIGN: begin
				emit_v  = minus_q;
				emit_ch = CH_MINUS;
			end
			P_INT: begin
				emit_v    = (idx_q == 5'd0) || (d_int != 4'd0) || started_q;
				emit_ch   = CH_ZERO | {3'd0, d_int};
				emit_last = (idx_q == 5'd0) && (p_q == 5'd0);
			end
			P_POINT: begin
				emit_v  = 1'b1;
				emit_ch = CH_DOT;
			end
			P_FRAC: begin
				emit_v    = 1'b1;
				emit_ch   = CH_ZERO | {3'd0, d_frc};
				emit_last = (idx_q == 5'd0);
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
	end

	// a new word enters the output register
	logic ov_set;
	assign ov_set = slot_free && ((state_q == S_ERR) || (state_q == S_EMIT && emit_v));

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ov_set) begin
			ov_q <= 1'b1;
		end else if (dout.ready) begin
			ov_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= P_SIGN;
			idx_q     <= '0;
			cnt_q     <= '0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (din.valid)
						state_q <= S_DEC;
				end
				S_DEC: begin
					cnt_q   <= p_q;
					state_q <= err_d ? S_ERR : S_MUL;
				end
				S_ERR: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				S_MUL: begin
					if (cnt_q == 5'd0)
						state_q <= S_RND;
					else
						cnt_q <= cnt_q - 5'd1;
				end
				S_RND: state_q <= S_FIX;
				S_FIX: state_q <= S_NAR;
				S_NAR: state_q <= S_BINT;
				S_BINT: begin
					if (!bcd_busy)
						state_q <= S_BFRC;
				end
				S_BFRC: begin
					if (!bcd_busy) begin
						state_q   <= S_EMIT;
						phase_q   <= P_SIGN;
						started_q <= 1'b0;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						case (phase_q)
							P_SIGN: begin
								phase_q <= P_INT;
								idx_q   <= 5'(INT_DIGITS - 1);
							end
							P_INT: begin
								if (emit_v)
									started_q <= 1'b1;
								if (idx_q == 5'd0) begin
									if (p_q == 5'd0) begin
										state_q <= S_IDLE;
									end else begin
										phase_q <= P_POINT;
									end
								end else begin
									idx_q <= idx_q - 5'd1;
								end
							end
							P_POINT: begin
								phase_q <= P_FRAC;
								idx_q   <= p_q - 5'd1;
							end
							P_FRAC: begin
								if (idx_q == 5'd0)
									state_q <= S_IDLE;
								else
									idx_q <= idx_q - 5'd1;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (din.valid) begin
					bits_q <= din.value_bits;
					p_q    <= p_clamp;
				end
			end
			S_DEC: begin
				ip_q  <= ipart;
				acc_q <= {{(ACC_W-FRAC_W){1'b0}}, fscaled};
				pw_q  <= PW_W'(1);
				neg_q <= bits_q[63];
				nz_q  <= (bits_q[62:0] != 63'd0);
			end
			S_ERR: begin
				if (slot_free) begin
					ch_q   <= CH_NONE;
					last_q <= 1'b1;
					err_q  <= 1'b1;
				end
			end
			S_MUL: begin
				if (cnt_q != 5'd0) begin
					acc_q <= (acc_q << 3) + (acc_q << 1);
					pw_q  <= (pw_q << 3) + (pw_q << 1);
				end
			end
			S_RND: rnd_q <= rsum[ACC_W-1:FRAC_W];
			S_FIX: begin
				if (rnd_q >= pw_q) begin
					ip_q  <= ip_q + 64'd1;
					rnd_q <= rnd_q - pw_q;
				end
			end
			S_NAR: minus_q <= minus_d;
			S_BINT: begin
				if (!bcd_busy)
					for (int i = 0; i < INT_DIGITS; i++)
						int_q[i] <= bcd_digits[4*i +: 4];
			end
			S_BFRC: begin
				if (!bcd_busy)
					for (int i = 0; i < MAX_FRACTION_DIGITS; i++)
						frc_q[i] <= bcd_digits[4*i +: 4];
			end
			S_EMIT: begin
				if (slot_free && emit_v) begin
					ch_q   <= emit_ch;
					last_q <= emit_last;
					err_q  <= 1'b0;
				end
			end
			default: begin
				ch_q <= ch_q;
			end
		endcase
	end

	assign din.ready         = (state_q == S_IDLE);
	assign dout.valid        = ov_q;
	assign dout.text_char    = ch_q;
	assign dout.is_last      = last_q;
	assign dout.out_of_range = err_q;

	// checks
	`DTDS_ASSERT_NOW(a_err_is_last, clk, arst_n, ov_q && err_q, last_q, "error word not last")
	`DTDS_ASSERT_NEXT(a_accept_decodes, clk, arst_n, din.valid && din.ready, state_q == S_DEC,
		"accepted word not decoded")
	`DTDS_ASSERT_NOW(a_emit_bcd_idle, clk, arst_n, state_q == S_EMIT, !bcd_busy,
		"BCD unit busy while streaming")
	`DTDS_ASSERT_NOW(a_frac_reduced, clk, arst_n, state_q == S_NAR, rnd_q < pw_q,
		"rounded fraction not reduced")
endmodule
